// ----- rtl/tcf_pkg.sv -----
package tcf_pkg;

    typedef enum logic [4:0] {
        K_ADD  = 5'd0,  K_SUB  = 5'd1,  K_MUL  = 5'd2,  K_DIV  = 5'd3,
        K_MOD  = 5'd4,  K_AND  = 5'd5,  K_OR   = 5'd6,  K_XOR  = 5'd7,
        K_SHL  = 5'd8,  K_SHR  = 5'd9,  K_LAND = 5'd10, K_LOR  = 5'd11,
        K_EQ   = 5'd12, K_NE   = 5'd13, K_LT   = 5'd14, K_LE   = 5'd15,
        K_GT   = 5'd16, K_GE   = 5'd17, K_POS  = 5'd18, K_NEG  = 5'd19,
        K_NOT  = 5'd20, K_LNOT = 5'd21, K_CAST = 5'd22
    } kind_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic        type_wide;
        logic        type_unsigned;
    } in_word_t;

    typedef struct packed {
        logic [31:0] value;
        logic        div_by_zero;
    } out_word_t;

    function automatic logic [31:0] cast_to_type(logic [31:0] v, logic wide, logic uns);
        logic [31:0] r;
        begin
            if (wide)
                r = v;
            else
                r = {{24{~uns & v[7]}}, v[7:0]};
            return r;
        end
    endfunction

endpackage

// ----- rtl/tcf_if.sv -----
interface tcf_in_if;
    logic             valid;
    logic             ready;
    tcf_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcf_out_if;
    logic              valid;
    logic              ready;
    tcf_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tcf_divider.sv -----
// Pipelined restoring divider on magnitudes, BPS quotient bits per stage.
// Sideband rides alongside.
module tcf_divider #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [31:0]       in_num,
    input  logic [31:0]       in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [31:0]       out_quo,
    output logic [31:0]       out_rem,
    output logic [SIDE_W-1:0] out_side
);
    localparam int unsigned STAGES = 8;
    localparam int unsigned BPS    = 32 / STAGES;

    logic [STAGES:1]       v_reg;
    logic [31:0]           num_reg  [1:STAGES];
    logic [31:0]           den_reg  [1:STAGES];
    logic [32:0]           rem_reg  [1:STAGES];
    logic [SIDE_W-1:0]     side_reg [1:STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic              v_cur;
        logic [31:0]       num_cur;
        logic [31:0]       den_cur;
        logic [32:0]       rem_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [32:0]       rem_next;
        logic [31:0]       num_next;

        if (s == 0)
        begin : g_first
            assign v_cur    = in_valid;
            assign num_cur  = in_num;
            assign den_cur  = in_den;
            assign rem_cur  = 33'd0;
            assign side_cur = in_side;
        end
        else
        begin : g_rest
            assign v_cur    = v_reg[s];
            assign num_cur  = num_reg[s];
            assign den_cur  = den_reg[s];
            assign rem_cur  = rem_reg[s];
            assign side_cur = side_reg[s];
        end

        always_comb
        begin
            rem_next = rem_cur;
            num_next = num_cur;
            for (int i = 0; i < BPS; i++)
            begin
                rem_next = {rem_next[31:0], num_next[31]};
                num_next = {num_next[30:0], 1'b0};
                if (rem_next >= {1'b0, den_cur})
                begin
                    rem_next   = rem_next - {1'b0, den_cur};
                    num_next[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (advance)
                v_reg[s+1] <= v_cur;
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                num_reg[s+1]  <= num_next;
                rem_reg[s+1]  <= rem_next;
                den_reg[s+1]  <= den_cur;
                side_reg[s+1] <= side_cur;
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_quo   = num_reg[STAGES];
    assign out_rem   = rem_reg[STAGES][31:0];
    assign out_side  = side_reg[STAGES];
endmodule

// ----- rtl/typed_constant_fold_alu.sv -----
// Typed constant-fold ALU. One word in, one word out, in order; a new word
// may enter every cycle unless the output stalls. The pipe has one cast/decode
// stage, eight divider stages (four quotient bits each) that every word passes
// through so results stay in order, a result stage and an output register.
// The whole pipe advances when the output register is empty or being taken,
// so a stall holds every stage and nothing is lost or repeated.
module typed_constant_fold_alu (
    input logic     clk,
    input logic     rst_n,
    tcf_in_if.sink  in_ch,
    tcf_out_if.source out_ch
);
    // sideband: kind, l, r, a, uns, wide, prod
    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] a;
        logic        uns;
        logic        wide;
        logic [31:0] prod;
    } side_t;

    logic advance;
    assign advance     = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = advance;

    // stage 0: cast, product, magnitudes
    logic        s0_v_reg;
    side_t       s0_reg;
    logic [31:0] s0_num_reg, s0_den_reg;
    logic [31:0] l_c, r_c;

    always_comb
    begin
        l_c = tcf_pkg::cast_to_type(in_ch.data.operand_a, in_ch.data.type_wide,
                                    in_ch.data.type_unsigned);
        r_c = tcf_pkg::cast_to_type(in_ch.data.operand_b, in_ch.data.type_wide,
                                    in_ch.data.type_unsigned);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (advance)
            s0_v_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg.kind <= in_ch.data.kind;
            s0_reg.l    <= l_c;
            s0_reg.r    <= r_c;
            s0_reg.a    <= in_ch.data.operand_a;
            s0_reg.uns  <= in_ch.data.type_unsigned;
            s0_reg.wide <= in_ch.data.type_wide;
            s0_reg.prod <= l_c * r_c;
            // signed division works on magnitudes
            s0_num_reg  <= (!in_ch.data.type_unsigned && l_c[31]) ? 32'd0 - l_c : l_c;
            s0_den_reg  <= (!in_ch.data.type_unsigned && r_c[31]) ? 32'd0 - r_c : r_c;
        end
    end

    logic        d_v;
    logic [31:0] d_quo, d_rem;
    side_t       d_side;

    tcf_divider #(.SIDE_W($bits(side_t))) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (s0_v_reg),
        .in_num   (s0_num_reg),
        .in_den   (s0_den_reg),
        .in_side  (s0_reg),
        .out_valid(d_v),
        .out_quo  (d_quo),
        .out_rem  (d_rem),
        .out_side (d_side)
    );

    // result select
    logic [31:0] res;
    logic        dz;
    logic        slt, sgt, lt, gt;
    logic [31:0] l, r;

    always_comb
    begin
        l   = d_side.l;
        r   = d_side.r;
        slt = $signed(l) < $signed(r);
        sgt = $signed(l) > $signed(r);
        lt  = d_side.uns ? (l < r) : slt;
        gt  = d_side.uns ? (l > r) : sgt;
        res = 32'd0;
        dz  = 1'b0;
        unique case (d_side.kind)
            tcf_pkg::K_ADD:  res = l + r;
            tcf_pkg::K_SUB:  res = l - r;
            tcf_pkg::K_MUL:  res = d_side.prod;
            tcf_pkg::K_DIV:
            begin
                dz = (r == 32'd0);
                if (dz)
                    res = 32'd0;
                else if (!d_side.uns && (l[31] ^ r[31]))
                    res = 32'd0 - d_quo;
                else
                    res = d_quo;
            end
            tcf_pkg::K_MOD:
            begin
                dz = (r == 32'd0);
                if (dz)
                    res = 32'd0;
                else if (!d_side.uns && l[31])
                    res = 32'd0 - d_rem;
                else
                    res = d_rem;
            end
            tcf_pkg::K_AND:  res = l & r;
            tcf_pkg::K_OR:   res = l | r;
            tcf_pkg::K_XOR:  res = l ^ r;
            tcf_pkg::K_SHL:  res = (r[31:5] != 27'd0) ? 32'd0 : (l << r[4:0]);
            tcf_pkg::K_SHR:
            begin
                if (d_side.uns || !l[31])
                    res = (r[31:5] != 27'd0) ? 32'd0 : (l >> r[4:0]);
                else
                    res = (r[31:5] != 27'd0) ? 32'hFFFF_FFFF : ~((~l) >> r[4:0]);
            end
            tcf_pkg::K_LAND: res = {31'd0, (l != 32'd0) && (r != 32'd0)};
            tcf_pkg::K_LOR:  res = {31'd0, (l != 32'd0) || (r != 32'd0)};
            tcf_pkg::K_EQ:   res = {31'd0, l == r};
            tcf_pkg::K_NE:   res = {31'd0, l != r};
            tcf_pkg::K_LT:   res = {31'd0, lt};
            tcf_pkg::K_LE:   res = {31'd0, !gt};
            tcf_pkg::K_GT:   res = {31'd0, gt};
            tcf_pkg::K_GE:   res = {31'd0, !lt};
            tcf_pkg::K_POS:  res = d_side.a;
            tcf_pkg::K_NEG:  res = 32'd0 - d_side.a;
            tcf_pkg::K_NOT:  res = ~d_side.a;
            tcf_pkg::K_LNOT: res = {31'd0, d_side.a == 32'd0};
            tcf_pkg::K_CAST: res = tcf_pkg::cast_to_type(d_side.a, d_side.wide, d_side.uns);
            default:         res = 32'd0;
        endcase
    end

    // result stage then output register
    logic                r_v_reg;
    tcf_pkg::out_word_t  r_reg;
    logic                o_v_reg;
    tcf_pkg::out_word_t  o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            r_v_reg <= d_v;
            o_v_reg <= r_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r_reg <= '{value: res, div_by_zero: dz};
            o_reg <= r_reg;
        end
    end

    assign out_ch.valid = o_v_reg;
    assign out_ch.data  = o_reg;
endmodule

// ----- rtl/tcf_checker.sv -----
module tcf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input tcf_pkg::out_word_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed under stall");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while output empty");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipe stalled");

    a_dz_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.div_by_zero |-> out_data.value == 32'd0)
        else $error("divide by zero with non-zero value");
endmodule

bind typed_constant_fold_alu tcf_checker u_tcf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data (out_ch.data)
);

// ----- tb/sv/tb_typed_constant_fold_alu.sv -----
`timescale 1ns / 1ps

module tb_typed_constant_fold_alu;

    logic clk;
    logic rst_n;

    tcf_in_if  in_ch ();
    tcf_out_if out_ch ();

    typed_constant_fold_alu uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // expected result words, oldest first
    tcf_pkg::out_word_t fold_q[$];
    int        err_cnt = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop; slowest correct run is far below this
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    // cast of one operand to the operation type
    function automatic logic [31:0] to_type(logic [31:0] v, logic wide, logic uns);
        logic [31:0] r;
        if (wide)
            r = v;
        else if (!uns && v[7])
            r = {24'hFFFFFF, v[7:0]};
        else
            r = {24'h0, v[7:0]};
        return r;
    endfunction

    // folds one typed operation the way the block should
    function automatic tcf_pkg::out_word_t fold_word(tcf_pkg::in_word_t w);
        tcf_pkg::out_word_t o;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] ml;
        logic [31:0] mr;
        logic        uns;
        logic        lt_s;
        logic        gt_s;
        uns = w.type_unsigned;
        l   = to_type(w.operand_a, w.type_wide, uns);
        r   = to_type(w.operand_b, w.type_wide, uns);
        ml  = l[31] ? -l : l;
        mr  = r[31] ? -r : r;
        lt_s = $signed(l) < $signed(r);
        gt_s = $signed(l) > $signed(r);
        o.value = '0;
        o.div_by_zero = 1'b0;
        case (w.kind)
            tcf_pkg::K_ADD:  o.value = l + r;
            tcf_pkg::K_SUB:  o.value = l - r;
            tcf_pkg::K_MUL:  o.value = l * r;
            tcf_pkg::K_DIV, tcf_pkg::K_MOD:
            begin
                if (r == 0)
                    o.div_by_zero = 1'b1;
                else if (uns)
                    o.value = (w.kind == tcf_pkg::K_DIV) ? l / r : l % r;
                else if (w.kind == tcf_pkg::K_DIV)
                    o.value = (l[31] ^ r[31]) ? -(ml / mr) : ml / mr;
                else
                    o.value = l[31] ? -(ml % mr) : ml % mr;
            end
            tcf_pkg::K_AND:  o.value = l & r;
            tcf_pkg::K_OR:   o.value = l | r;
            tcf_pkg::K_XOR:  o.value = l ^ r;
            tcf_pkg::K_SHL:  o.value = (r >= 32) ? '0 : l << r[4:0];
            tcf_pkg::K_SHR:
            begin
                if (uns || !l[31])
                    o.value = (r >= 32) ? '0 : l >> r[4:0];
                else
                    o.value = (r >= 32) ? '1 : ~((~l) >> r[4:0]);
            end
            tcf_pkg::K_LAND: o.value = {31'b0, (l != 0) && (r != 0)};
            tcf_pkg::K_LOR:  o.value = {31'b0, (l != 0) || (r != 0)};
            tcf_pkg::K_EQ:   o.value = {31'b0, l == r};
            tcf_pkg::K_NE:   o.value = {31'b0, l != r};
            tcf_pkg::K_LT:   o.value = {31'b0, uns ? l < r : lt_s};
            tcf_pkg::K_LE:   o.value = {31'b0, uns ? l <= r : !gt_s};
            tcf_pkg::K_GT:   o.value = {31'b0, uns ? l > r : gt_s};
            tcf_pkg::K_GE:   o.value = {31'b0, uns ? l >= r : !lt_s};
            tcf_pkg::K_POS:  o.value = w.operand_a;
            tcf_pkg::K_NEG:  o.value = -w.operand_a;
            tcf_pkg::K_NOT:  o.value = ~w.operand_a;
            tcf_pkg::K_LNOT: o.value = {31'b0, w.operand_a == 0};
            tcf_pkg::K_CAST: o.value = to_type(w.operand_a, w.type_wide, w.type_unsigned);
            default: o.value = '0;
        endcase
        return o;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(30, 8);
    endfunction

    task automatic send_word(tcf_pkg::in_word_t w);
        int g;
        g = gap_len();
        // valid drops only for a gap; back to back words keep it high
        if (g != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        fold_q.push_back(fold_word(w));
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // output side: random back-pressure, checks each accepted word
    initial
    begin
        tcf_pkg::out_word_t exp_w;
        int        g;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (fold_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    err_cnt++;
                end
                else
                begin
                    exp_w = fold_q.pop_front();
                    if (out_ch.data.value !== exp_w.value)
                    begin
                        $error("value: expected %h, got %h", exp_w.value, out_ch.data.value);
                        err_cnt++;
                    end
                    if (out_ch.data.div_by_zero !== exp_w.div_by_zero)
                    begin
                        $error("div_by_zero: expected %b, got %b",
                               exp_w.div_by_zero, out_ch.data.div_by_zero);
                        err_cnt++;
                    end
                end
            end
        end
    end

    function automatic tcf_pkg::in_word_t mk(tcf_pkg::kind_t k, logic [31:0] a,
                                             logic [31:0] b, logic wd, logic un);
        tcf_pkg::in_word_t w;
        w.kind = k;
        w.operand_a = a;
        w.operand_b = b;
        w.type_wide = wd;
        w.type_unsigned = un;
        return w;
    endfunction

    // edges: zero divisor, min / -1, big and negative shift counts, byte casts
    task automatic test_directed();
        send_word(mk(tcf_pkg::K_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send_word(mk(tcf_pkg::K_MOD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send_word(mk(tcf_pkg::K_DIV, 32'h1234, 32'h0, 1'b1, 1'b1));
        send_word(mk(tcf_pkg::K_MOD, 32'h1234, 32'h100, 1'b0, 1'b0));
        send_word(mk(tcf_pkg::K_DIV, 32'h80, 32'hFF, 1'b0, 1'b0));
        send_word(mk(tcf_pkg::K_DIV, 32'hFFFF_FFF9, 32'h2, 1'b1, 1'b0));
        send_word(mk(tcf_pkg::K_MOD, 32'hFFFF_FFF9, 32'h2, 1'b1, 1'b0));
        send_word(mk(tcf_pkg::K_SHL, 32'h1, 32'd32, 1'b1, 1'b1));
        send_word(mk(tcf_pkg::K_SHL, 32'hFFFF_FFFF, 32'd31, 1'b1, 1'b0));
        send_word(mk(tcf_pkg::K_SHR, 32'h8000_0000, 32'd40, 1'b1, 1'b0));
        send_word(mk(tcf_pkg::K_SHR, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_word(mk(tcf_pkg::K_SHR, 32'h80, 32'hFF, 1'b0, 1'b0));
        send_word(mk(tcf_pkg::K_SHR, 32'h8000_0000, 32'd4, 1'b1, 1'b0));
        send_word(mk(tcf_pkg::K_LT, 32'h80, 32'h7F, 1'b0, 1'b0));
        send_word(mk(tcf_pkg::K_LT, 32'h80, 32'h7F, 1'b0, 1'b1));
        send_word(mk(tcf_pkg::K_GE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0));
        send_word(mk(tcf_pkg::K_CAST, 32'hFFFF_FF80, 32'h0, 1'b0, 1'b0));
        send_word(mk(tcf_pkg::K_CAST, 32'hFFFF_FF80, 32'h0, 1'b0, 1'b1));
        send_word(mk(tcf_pkg::K_NEG, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0));
        send_word(mk(tcf_pkg::K_LNOT, 32'h0, 32'h0, 1'b0, 1'b0));
        send_word(mk(tcf_pkg::K_NOT, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_word(mk(tcf_pkg::K_LAND, 32'h100, 32'h1, 1'b0, 1'b1));
        send_word(mk(tcf_pkg::K_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_word(mk(tcf_pkg::kind_t'(5'd31), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom_range(3);
            1: return 32'hFFFF_FFFF - $urandom_range(2);
            2: return 32'h8000_0000 ^ $urandom_range(1);
            3: return $urandom_range(40);
            default: return $urandom();
        endcase
    endfunction

    // random kinds over all 32 codes, corner-heavy operands
    task automatic test_random(int n);
        tcf_pkg::in_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w.kind = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 23))
                                               : 5'($urandom_range(22));
            w.operand_a = rand_operand();
            w.operand_b = rand_operand();
            w.type_wide = 1'($urandom_range(1));
            w.type_unsigned = 1'($urandom_range(1));
            send_word(w);
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1875);
        in_ch.valid <= 1'b0;
        waited = 0;
        while (fold_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        // pipe is 11 deep; allow stray words to show up
        repeat (40) @(posedge clk);
        if (err_cnt == 0 && fold_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
